>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property, disabled while reset is asserted.
`define NFK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A valid that is not taken stays up in the next cycle.
`define NFK_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> vld) \
        else $error("valid dropped before the request was taken");

`endif

>>> rtl/nfk_pkg.sv
// Shared types and constants of the next free key finder.
package nfk_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 2);

    localparam int IN_ITEM_W   = IDX_W + KEY_W + CNT_W;
    localparam int IN_TDATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
    localparam int IN_PAD_W    = IN_TDATA_W - IN_ITEM_W;
    localparam int OUT_ITEM_W  = KEY_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_ITEM_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_ITEM_W;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIS,
        S_BIS_CMP,
        S_CHK,
        S_WALK,
        S_WALK_CMP,
        S_DONE
    } t_state;

    // Request item, last field in the lowest bits.
    typedef struct packed {
        logic [CNT_W-1:0] entries_used;
        logic [KEY_W-1:0] key_value;
        logic [IDX_W-1:0] entry_index;
    } t_in_item;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [CNT_W-1:0] insert_position;
        logic [KEY_W-1:0] free_key;
    } t_result;

    typedef struct packed {
        logic             en;
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] wdata;
    } t_ram_req;

endpackage

>>> rtl/nfk_ram.sv
// Generic single-port RAM with registered read data.
module nfk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/nfk_seq.sv
// Search sequencer: bisection, forward walk and table writes over the key RAM.
module nfk_seq import nfk_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_cmd,
    input  t_in_item         i_item,
    output logic             o_ready,
    output t_ram_req         o_ram_req,
    input  logic [KEY_W-1:0] i_ram_rdata,
    output logic             o_res_valid,
    output t_result          o_res,
    input  logic             i_res_ready
);

    t_state           r_state, n_state;
    logic [KEY_W-1:0] r_key, n_key;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic             r_second, n_second;
    logic             r_restart, n_restart;

    logic [CNT_W:0]   w_sum;
    logic [CNT_W-1:0] w_mid;
    logic [CNT_W-1:0] w_mid_m1;
    logic [CNT_W-1:0] w_lo_m1;
    logic [CNT_W-1:0] w_span;
    logic             w_more;
    logic [CNT_W-1:0] w_cnt_sat;
    logic [KEY_W-1:0] w_key_inc;
    logic             w_walk_in;
    logic             w_hit;

    assign w_sum     = {1'b0, r_hi} + {1'b0, r_lo};
    assign w_mid     = w_sum[CNT_W:1];
    assign w_mid_m1  = w_mid - CNT_W'(1);
    assign w_lo_m1   = r_lo - CNT_W'(1);
    assign w_span    = r_hi - r_lo;
    assign w_more    = (w_span > CNT_W'(1));
    assign w_cnt_sat = (i_item.entries_used > CNT_W'(TABLE_DEPTH)) ?
                       CNT_W'(TABLE_DEPTH) : i_item.entries_used;
    assign w_key_inc = r_key + KEY_W'(1);
    assign w_walk_in = (r_pos < r_cnt);
    assign w_hit     = (i_ram_rdata == r_key);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && (i_cmd == CMD_QUERY)) n_state = S_BIS;
            end
            S_BIS: begin
                if (w_more) n_state = S_BIS_CMP;
                else if (r_second || (r_lo == '0)) n_state = S_DONE;
                else n_state = S_CHK;
            end
            S_BIS_CMP: n_state = S_BIS;
            S_CHK: begin
                n_state = w_hit ? S_WALK : S_DONE;
            end
            S_WALK: begin
                n_state = w_walk_in ? S_WALK_CMP : S_BIS;
            end
            S_WALK_CMP: begin
                priority if (i_ram_rdata < r_key) n_state = S_WALK;
                else if (w_hit) n_state = ((w_key_inc == '0) && r_restart) ? S_BIS : S_WALK;
                else n_state = S_BIS;
            end
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_key       = r_key;
        n_cnt       = r_cnt;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pos       = r_pos;
        n_second    = r_second;
        n_restart   = r_restart;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_ram_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_cmd == CMD_WRITE) begin
                        o_ram_req.en    = 1'b1;
                        o_ram_req.we    = 1'b1;
                        o_ram_req.addr  = i_item.entry_index;
                        o_ram_req.wdata = i_item.key_value;
                    end else begin
                        n_key    = i_item.key_value;
                        n_cnt    = w_cnt_sat;
                        n_lo     = '0;
                        n_hi     = w_cnt_sat + CNT_W'(1);
                        n_second = 1'b0;
                    end
                end
            end
            S_BIS: begin
                // Probe the middle entry, or the entry left of the insertion point.
                if (w_more) begin
                    o_ram_req.en   = 1'b1;
                    o_ram_req.addr = w_mid_m1[IDX_W-1:0];
                end else if (!r_second && (r_lo != '0)) begin
                    o_ram_req.en   = 1'b1;
                    o_ram_req.addr = w_lo_m1[IDX_W-1:0];
                end
            end
            S_BIS_CMP: begin
                if (r_key >= i_ram_rdata) n_lo = w_mid;
                else n_hi = w_mid;
            end
            S_CHK: begin
                if (w_hit) begin
                    n_pos     = w_lo_m1;
                    n_restart = 1'b0;
                end
            end
            S_WALK: begin
                if (w_walk_in) begin
                    o_ram_req.en   = 1'b1;
                    o_ram_req.addr = r_pos[IDX_W-1:0];
                end else begin
                    n_lo     = '0;
                    n_hi     = r_cnt + CNT_W'(1);
                    n_second = 1'b1;
                end
            end
            S_WALK_CMP: begin
                priority if (i_ram_rdata < r_key) begin
                    n_pos = r_pos + CNT_W'(1);
                end else if (w_hit) begin
                    n_key = w_key_inc;
                    if (w_key_inc == '0) begin
                        if (r_restart) begin
                            n_lo     = '0;
                            n_hi     = r_cnt + CNT_W'(1);
                            n_second = 1'b1;
                        end else begin
                            n_restart = 1'b1;
                            n_pos     = '0;
                        end
                    end else begin
                        // Entry equals the old key, so it is below the new one.
                        n_pos = r_pos + CNT_W'(1);
                    end
                end else begin
                    n_lo     = '0;
                    n_hi     = r_cnt + CNT_W'(1);
                    n_second = 1'b1;
                end
            end
            S_DONE: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_res.free_key        = r_key;
    assign o_res.insert_position = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_cnt     <= n_cnt;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_pos     <= n_pos;
        r_second  <= n_second;
        r_restart <= n_restart;
    end

endmodule

>>> rtl/next_free_unique_key_finder_core.sv
// Sequence: a write is taken in idle; a query runs a bisection (ceil(log2(n+1)) steps for n
// entries in use), a match check, then on a match a walk over the entries or keys visited and
// a second bisection; the result then moves into the output register.
// Throughput: one query at a time on the single read port of the key RAM; writes one per cycle
// while no query is in progress.
// Reset: synchronous, active low; clears sequencer state and output valid; table stays undefined.
module next_free_unique_key_finder_core import nfk_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // entry_index [9:0], key_value [25:10], entries_used [36:26], zero pad above
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // command [0]: 0 write entry, 1 query
    input  logic                   i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // free_key [15:0], insert_position [26:16], zero pad above
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    t_in_item         w_item;
    t_ram_req         w_ram_req;
    logic [KEY_W-1:0] w_ram_rdata;
    logic             w_res_valid;
    t_result          w_res;
    logic             w_res_ready;

    logic             r_out_valid;
    t_result          r_out_data;

    assign w_item = i_s_tdata[IN_ITEM_W-1:0];

    // Sequencer owns the RAM port: writes in idle, search reads otherwise.
    nfk_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_cmd       (i_s_tuser),
        .i_item      (w_item),
        .o_ready     (o_s_tready),
        .o_ram_req   (w_ram_req),
        .i_ram_rdata (w_ram_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    nfk_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_en    (w_ram_req.en),
        .i_we    (w_ram_req.we),
        .i_addr  (w_ram_req.addr),
        .i_wdata (w_ram_req.wdata),
        .o_rdata (w_ram_rdata)
    );

    // Output register: load a finished result when the slot is empty or being drained,
    // so the next request is taken while a result still waits.
    assign w_res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_data <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_data};

endmodule

>>> rtl/nfk_checker.sv
// Port-level checker of the next free key finder, bound to the top level.
`include "assert_macros.svh"

module nfk_checker import nfk_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   i_s_tready,
    input logic                   i_s_tuser,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata
);

    logic w_s_acc;
    logic w_query_acc;

    assign w_s_acc     = i_s_tvalid && i_s_tready;
    assign w_query_acc = w_s_acc && (i_s_tuser == CMD_QUERY);

    `NFK_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, i_m_tvalid, i_m_tready)
    `NFK_ASSERT(a_out_stable, i_clk, i_rst_n, (i_m_tvalid && !i_m_tready) |=> $stable(i_m_tdata), "result changed while stalled")
    `NFK_ASSERT(a_query_busy, i_clk, i_rst_n, w_query_acc |=> !i_s_tready, "request taken during a query")
    `NFK_ASSERT(a_no_early_res, i_clk, i_rst_n, (w_s_acc && !i_m_tvalid) |=> !i_m_tvalid, "result appeared too early")

endmodule

bind next_free_unique_key_finder_core nfk_checker u_nfk_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

>>> tb/tb_top.sv
// Self-checking testbench of the next free key finder: writes and free key queries.
`timescale 1ns / 1ps

module tb_top;
    import nfk_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 60;   // last random requests go without any idling
    localparam int LONG_HOLD    = 300;  // receiver hold-off that backs up the block
    localparam int DRAIN_CYCLES = 64;
    localparam int KEY_SPAN     = 1 << KEY_W;

    // One request as the stimulus sees it, with an optional typed-in answer.
    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
        logic             typed;
        logic [KEY_W-1:0] exp_key;
        logic [CNT_W-1:0] exp_pos;
    } t_stim;

    // Opening requests: empty table, a short sorted table with runs and a wrap.
    localparam t_stim DIRECTED_ROWS [17] = '{
        '{CMD_QUERY, 0,    0,     0, 1, 0,     0},  // nothing in use, smallest key
        '{CMD_QUERY, 0,    65535, 0, 1, 65535, 0},  // nothing in use, largest key
        '{CMD_WRITE, 0,    0,     0, 0, 0,     0},
        '{CMD_WRITE, 1,    1,     0, 0, 0,     0},
        '{CMD_WRITE, 2,    2,     0, 0, 0,     0},
        '{CMD_WRITE, 3,    5,     0, 0, 0,     0},
        '{CMD_WRITE, 4,    100,   0, 0, 0,     0},
        '{CMD_WRITE, 5,    65534, 0, 0, 0,     0},
        '{CMD_WRITE, 6,    65535, 0, 0, 0,     0},
        '{CMD_QUERY, 0,    0,     7, 0, 0,     0},  // walk over a run from the head
        '{CMD_QUERY, 0,    4,     7, 1, 4,     3},  // key is free already
        '{CMD_QUERY, 0,    65534, 7, 0, 0,     0},  // walk off the top, restart at zero
        '{CMD_QUERY, 0,    100,   7, 0, 0,     0},
        '{CMD_QUERY, 0,    65535, 1, 0, 0,     0},
        '{CMD_QUERY, 0,    1,     3, 0, 0,     0},  // walk stops at the end of the table
        '{CMD_QUERY, 0,    200,   0, 1, 200,   0},
        '{CMD_WRITE, 1023, 65535, 0, 0, 0,     0}   // highest index
    };

    // Queries against a full table holding the top TABLE_DEPTH keys.
    localparam t_stim FULL_TABLE_ROWS [5] = '{
        '{CMD_QUERY, 0, 65535, 2047, 1, 0,     0},  // count saturates, key wraps to zero
        '{CMD_QUERY, 0, 64511, 1024, 1, 64511, 0},
        '{CMD_QUERY, 0, 64512, 1500, 0, 0,     0},  // walk the whole table
        '{CMD_QUERY, 0, 0,     1024, 0, 0,     0},
        '{CMD_QUERY, 0, 65000, 1023, 0, 0,     0}
    };

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // entry_index [9:0], key_value [25:10], entries_used [36:26], zero pad above
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    // command [0]: 0 write entry, 1 query
    logic                   i_s_tuser  = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // free_key [15:0], insert_position [26:16], zero pad above
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];   // shadow of the key table
    t_result          expected_free_q [$];     // answers of accepted queries, oldest first
    int unsigned      err_count    = 0;
    int unsigned      items_sent   = 0;
    int unsigned      calm_mark    = '1;
    bit               sender_idles = 1'b1;
    bit               hold_off_req = 1'b0;

    next_free_unique_key_finder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        err_count++;
    endtask

    // Position just after the last entry not greater than the key.
    function automatic int unsigned insert_point(input int unsigned count,
                                                 input int unsigned key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = count + 1;
        while (hi - lo > 1) begin
            mid = (hi + lo) >> 1;
            if (key >= key_mem[mid-1]) lo = mid;
            else                       hi = mid;
        end
        return lo;
    endfunction

    // Step past taken keys from entry pos; one restart at entry zero after a wrap.
    function automatic int unsigned skip_taken_keys(input int unsigned count,
                                                    input int unsigned key,
                                                    input int unsigned pos);
        int unsigned restarts;
        bit          done;
        restarts = 0;
        done     = 1'b0;
        while (!done && pos < count) begin
            if (key_mem[pos] < key) begin
                pos++;
            end else if (key_mem[pos] == key) begin
                key = (key + 1) % KEY_SPAN;
                if (key == 0) begin
                    if (restarts != 0) begin
                        done = 1'b1;
                    end else begin
                        restarts++;
                        pos = 0;
                    end
                end
            end else begin
                done = 1'b1;
            end
        end
        return key;
    endfunction

    function automatic t_result predict_free_key(input logic [KEY_W-1:0] start_key,
                                                 input logic [CNT_W-1:0] used);
        int unsigned count;
        int unsigned key;
        int unsigned pos;
        t_result     res;
        count = (used > TABLE_DEPTH) ? TABLE_DEPTH : used;
        key   = start_key;
        pos   = insert_point(count, key);
        if (pos > 0 && key_mem[pos-1] == key) begin
            key = skip_taken_keys(count, key, pos - 1);
            pos = insert_point(count, key);
        end
        res.free_key        = KEY_W'(key);
        res.insert_position = CNT_W'(pos);
        return res;
    endfunction

    // Update the shadow table on a write; queue the answer of a query.
    task automatic accept_request(input t_stim s);
        t_result res;
        if (s.cmd == CMD_WRITE) begin
            key_mem[s.idx] = s.key;
        end else begin
            res = predict_free_key(s.key, s.cnt);
            if (s.typed) begin
                res.free_key        = s.exp_key;
                res.insert_position = s.exp_pos;
            end
            expected_free_q.push_back(res);
        end
    endtask

    // Offer one request, hold it until taken, then maybe idle for a burst.
    task automatic offer_request(input t_stim s);
        t_in_item item;
        item.entry_index  = s.idx;
        item.key_value    = s.key;
        item.entries_used = s.cnt;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= s.cmd;
        i_s_tdata  <= {{IN_PAD_W{1'b0}}, item};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        accept_request(s);
        items_sent++;
        if (sender_idles && items_sent < calm_mark && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic write_entry(input int unsigned idx, input int unsigned key);
        t_stim s;
        s     = '0;
        s.cmd = CMD_WRITE;
        s.idx = IDX_W'(idx);
        s.key = KEY_W'(key);
        offer_request(s);
    endtask

    task automatic query_free(input int unsigned key, input int unsigned cnt);
        t_stim s;
        s     = '0;
        s.cmd = CMD_QUERY;
        s.key = KEY_W'(key);
        s.cnt = CNT_W'(cnt);
        offer_request(s);
    endtask

    // Load a sorted table with dense runs, then query it, mostly on stored keys.
    task automatic run_session();
        int unsigned keys [$];
        int unsigned n;
        int unsigned head;
        int unsigned tail;
        int unsigned k;
        int unsigned a;
        int unsigned b;
        int unsigned tmp;
        int unsigned nq;
        int unsigned pick;
        int unsigned cnt;
        int unsigned qkey;
        bit          rev;
        sender_idles = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 3) == 0) begin
            // runs at both ends of the key space, so queries wrap through zero
            n    = $urandom_range(3, 24);
            head = $urandom_range(1, n - 2);
            tail = $urandom_range(1, n - head - 1);
            for (int i = 0; i < head; i++) keys.push_back(i);
            k = $urandom_range(head + 1, 30000);
            for (int i = 0; i < n - head - tail; i++) begin
                keys.push_back(k);
                k += 1 + $urandom_range(0, 2);
            end
            for (int i = 0; i < tail; i++) keys.push_back(KEY_SPAN - tail + i);
        end else begin
            n = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
            k = $urandom_range(0, KEY_SPAN - 1 - 4 * n);
            for (int i = 0; i < n; i++) begin
                keys.push_back(k);
                k += 1 + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
            end
        end
        // break the ordering now and then
        if (n > 1 && $urandom_range(0, 9) == 0) begin
            a       = $urandom_range(0, n - 1);
            b       = $urandom_range(0, n - 1);
            tmp     = keys[a];
            keys[a] = keys[b];
            keys[b] = tmp;
        end
        rev = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            a = rev ? n - 1 - i : i;
            write_entry(a, keys[a]);
        end
        // stray write past the part in use
        if (n < TABLE_DEPTH && $urandom_range(0, 5) == 0)
            write_entry($urandom_range(n, TABLE_DEPTH - 1), $urandom_range(0, KEY_SPAN - 1));
        nq = $urandom_range(2, 6);
        for (int q = 0; q < nq; q++) begin
            pick = $urandom_range(0, 9);
            qkey = keys[$urandom_range(0, n - 1)];
            cnt  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n;
            case (pick)
                6: qkey = (qkey + KEY_SPAN - 1) % KEY_SPAN;
                7: qkey = (qkey + 1) % KEY_SPAN;
                8: qkey = $urandom_range(0, KEY_SPAN - 1);
                9: begin
                    cnt = $urandom_range(0, (1 << CNT_W) - 1);
                    if ($urandom_range(0, 1) == 0) qkey = $urandom_range(0, KEY_SPAN - 1);
                end
                default: ;
            endcase
            query_free(qkey, cnt);
        end
    endtask

    // Compare each result taken from the block with the oldest queued answer.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            got = o_m_tdata[OUT_ITEM_W-1:0];
            if (expected_free_q.size() == 0) begin
                flag_mismatch($sformatf("result key %0d pos %0d with no query pending",
                                        got.free_key, got.insert_position));
            end else begin
                want = expected_free_q.pop_front();
                if (got.free_key !== want.free_key)
                    flag_mismatch($sformatf("free_key %0d, want %0d",
                                            got.free_key, want.free_key));
                if (got.insert_position !== want.insert_position)
                    flag_mismatch($sformatf("insert_position %0d, want %0d",
                                            got.insert_position, want.insert_position));
            end
        end
    end

    // Receiver: random ready bursts, one long hold-off on request, none at the end.
    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (items_sent < calm_mark && $urandom_range(0, 2) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int unsigned phase_start;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) offer_request(DIRECTED_ROWS[r]);

        // Fill every entry with the top keys, then query the full table while
        // the receiver holds off so that the block backs up.
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) write_entry(i, KEY_SPAN - TABLE_DEPTH + i);
        hold_off_req = 1'b1;
        foreach (FULL_TABLE_ROWS[r]) offer_request(FULL_TABLE_ROWS[r]);

        phase_start = items_sent;
        calm_mark   = phase_start + RANDOM_ITEMS - CALM_ITEMS;
        while (items_sent - phase_start < RANDOM_ITEMS) run_session();
        i_s_tvalid <= 1'b0;

        while (expected_free_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #(10_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
